FILE: rtl/core/ssi_pkg.sv
package ssi_pkg;

	// Default coordinate width in bits (Q12.4 by default).
	localparam int COORD_WIDTH_DEF = 16;

	// Width of the parallel threshold register.
	localparam int THRESH_WIDTH = 34;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_OUTSIDE  = 2'd2
	} status_t;

	// Control word that travels alongside the arithmetic.
	typedef struct packed {
		logic    valid;
		status_t status;
	} tag_t;

endpackage

FILE: rtl/core/segment_segment_intersection_unit.sv
// Intersection of segment AB with segment CD in signed fixed point. A word is
// taken whenever start is high; busy is always low, so one pair of segments
// can enter in every cycle. Each word yields exactly one result, shown for one
// cycle with done high; between start and done lie three stages of Cramer's
// rule, four stages that build the point numerators, a restoring divider that
// retires one quotient bit per stage, and the output register. The receiver
// cannot stall the results. status is 0 for a hit, 1 when |det| is at or
// below parallel_threshold, and 2 when the lines cross outside the segments;
// the point is zero unless status is 0 and is rounded toward zero. Write
// parallel_threshold only while no word is in flight.
module segment_segment_intersection_unit #(
	parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_WIDTH-1:0]   a_x,
	input  logic signed [COORD_WIDTH-1:0]   a_y,
	input  logic signed [COORD_WIDTH-1:0]   b_x,
	input  logic signed [COORD_WIDTH-1:0]   b_y,
	input  logic signed [COORD_WIDTH-1:0]   c_x,
	input  logic signed [COORD_WIDTH-1:0]   c_y,
	input  logic signed [COORD_WIDTH-1:0]   d_x,
	input  logic signed [COORD_WIDTH-1:0]   d_y,
	input  logic                            parallel_threshold_we,
	input  logic [ssi_pkg::THRESH_WIDTH-1:0] parallel_threshold_wdata,
	output logic                            done,
	output ssi_pkg::status_t                status,
	output logic signed [COORD_WIDTH-1:0]   point_x,
	output logic signed [COORD_WIDTH-1:0]   point_y
);
	import ssi_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int DW  = 2 * W + 3;
	localparam int NW  = W + DW + 2;
	localparam int CW  = (DW > THRESH_WIDTH) ? DW : THRESH_WIDTH;
	localparam int TAG = W + 3;
	localparam int LAT = W + 8;

	logic [THRESH_WIDTH-1:0] thresh_q;
	logic                    accept;
	logic                    cr_valid;
	logic signed [W-1:0]     cr_ax, cr_ay;
	logic signed [W:0]       cr_ux, cr_uy;
	logic signed [DW-1:0]    cr_det, cr_tn, cr_sn;
	logic [DW-1:0]           det_mag;
	logic                    is_parallel, t_in, s_in;
	status_t                 status_c;
	tag_t                    tag_s [0:TAG];
	logic [NW-1:0]           px_n, py_n;
	logic [DW-1:0]           px_d, py_d;
	logic                    px_neg, py_neg;
	logic [W-1:0]            qx, qy;
	logic                    qx_neg, qy_neg;
	logic                    done_q;
	status_t                 status_q;
	logic signed [W-1:0]     point_x_q, point_y_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (parallel_threshold_we) begin
			thresh_q <= parallel_threshold_wdata;
		end
	end

	ssi_cramer #(.COORD_WIDTH(W)) u_cramer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.a_x      (a_x),
		.a_y      (a_y),
		.b_x      (b_x),
		.b_y      (b_y),
		.c_x      (c_x),
		.c_y      (c_y),
		.d_x      (d_x),
		.d_y      (d_y),
		.out_valid(cr_valid),
		.ax       (cr_ax),
		.ay       (cr_ay),
		.ux       (cr_ux),
		.uy       (cr_uy),
		.det      (cr_det),
		.tn       (cr_tn),
		.sn       (cr_sn)
	);

	// Classification: parallel test, then both parameters inside [0,1].
	always_comb begin
		det_mag     = cr_det[DW-1] ? DW'(-cr_det) : DW'(cr_det);
		is_parallel = CW'(det_mag) <= CW'(thresh_q);
		if (!cr_det[DW-1]) begin
			t_in = !cr_tn[DW-1] && (cr_tn <= cr_det);
			s_in = !cr_sn[DW-1] && (cr_sn <= cr_det);
		end else begin
			t_in = (cr_tn <= 0) && (cr_tn >= cr_det);
			s_in = (cr_sn <= 0) && (cr_sn >= cr_det);
		end
		priority if (is_parallel) begin
			status_c = ST_PARALLEL;
		end else if (t_in && s_in) begin
			status_c = ST_HIT;
		end else begin
			status_c = ST_OUTSIDE;
		end
	end

	// Status and valid ride a delay line that matches the point datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= TAG; i++) begin
				tag_s[i] <= '{valid: 1'b0, status: ST_HIT};
			end
		end else begin
			tag_s[0] <= '{valid: cr_valid, status: status_c};
			for (int i = 1; i <= TAG; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
		end
	end

	ssi_point #(.COORD_WIDTH(W)) u_point_x (
		.clk  (clk),
		.a    (cr_ax),
		.u    (cr_ux),
		.det  (cr_det),
		.tn   (cr_tn),
		.mag_n(px_n),
		.mag_d(px_d),
		.neg  (px_neg)
	);

	ssi_point #(.COORD_WIDTH(W)) u_point_y (
		.clk  (clk),
		.a    (cr_ay),
		.u    (cr_uy),
		.det  (cr_det),
		.tn   (cr_tn),
		.mag_n(py_n),
		.mag_d(py_d),
		.neg  (py_neg)
	);

	ssi_divider #(.COORD_WIDTH(W)) u_div_x (
		.clk    (clk),
		.num    (px_n),
		.den    (px_d),
		.neg    (px_neg),
		.quo    (qx),
		.quo_neg(qx_neg)
	);

	ssi_divider #(.COORD_WIDTH(W)) u_div_y (
		.clk    (clk),
		.num    (py_n),
		.den    (py_d),
		.neg    (py_neg),
		.quo    (qy),
		.quo_neg(qy_neg)
	);

	// Output register: done strobe with status and signed point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tag_s[TAG].valid;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= tag_s[TAG].status;
		if (tag_s[TAG].status == ST_HIT) begin
			point_x_q <= qx_neg ? W'(-qx) : W'(qx);
			point_y_q <= qy_neg ? W'(-qy) : W'(qy);
		end else begin
			point_x_q <= '0;
			point_y_q <= '0;
		end
	end

	assign done    = done_q;
	assign status  = status_q;
	assign point_x = point_x_q;
	assign point_y = point_y_q;

`ifndef ASSERT_OFF
	// Every accepted word comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LAT) done)
		else $error("result missing after fixed latency");

	// No result without an accepted word at the matching time.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s[TAG].valid |-> $past(cr_valid, TAG + 1))
		else $error("result tag without an entering word");

	// A miss reports the origin as its point.
	a_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_HIT) |-> (point_x == '0 && point_y == '0))
		else $error("point not zero on a miss");

	// Only the three defined codes are reported.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_HIT || status == ST_PARALLEL || status == ST_OUTSIDE))
		else $error("undefined status code");
`endif

endmodule

FILE: rtl/core/ssi_cramer.sv
module ssi_cramer #(
	parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] c_x,
	input  logic signed [COORD_WIDTH-1:0] c_y,
	input  logic signed [COORD_WIDTH-1:0] d_x,
	input  logic signed [COORD_WIDTH-1:0] d_y,
	output logic                          out_valid,
	output logic signed [COORD_WIDTH-1:0] ax,
	output logic signed [COORD_WIDTH-1:0] ay,
	output logic signed [COORD_WIDTH:0]   ux,
	output logic signed [COORD_WIDTH:0]   uy,
	output logic signed [2*COORD_WIDTH+2:0] det,
	output logic signed [2*COORD_WIDTH+2:0] tn,
	output logic signed [2*COORD_WIDTH+2:0] sn
);
	import ssi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int PW = 2 * (W + 1);
	localparam int DW = PW + 1;

	logic valid_s1, valid_s2, valid_s3;
	logic signed [W-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic signed [W:0]   ux_s1, uy_s1, vx_s1, vy_s1, ex_s1, ey_s1;
	logic signed [W:0]   ux_s2, uy_s2, ux_s3, uy_s3;
	logic signed [PW-1:0] p_uv_s2, p_vu_s2, p_ev_s2, p_ve_s2, p_ue_s2, p_eu_s2;
	logic signed [DW-1:0] det_s3, tn_s3, sn_s3;

	// Valid bits follow the words through the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: edge vectors u = B-A, v = C-D, e = C-A.
	always_ff @(posedge clk) begin
		ax_s1 <= a_x;
		ay_s1 <= a_y;
		ux_s1 <= (W+1)'(b_x) - (W+1)'(a_x);
		uy_s1 <= (W+1)'(b_y) - (W+1)'(a_y);
		vx_s1 <= (W+1)'(c_x) - (W+1)'(d_x);
		vy_s1 <= (W+1)'(c_y) - (W+1)'(d_y);
		ex_s1 <= (W+1)'(c_x) - (W+1)'(a_x);
		ey_s1 <= (W+1)'(c_y) - (W+1)'(a_y);
	end

	// Stage 2: the six cross products.
	always_ff @(posedge clk) begin
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		ux_s2   <= ux_s1;
		uy_s2   <= uy_s1;
		p_uv_s2 <= ux_s1 * vy_s1;
		p_vu_s2 <= vx_s1 * uy_s1;
		p_ev_s2 <= ex_s1 * vy_s1;
		p_ve_s2 <= vx_s1 * ey_s1;
		p_ue_s2 <= ux_s1 * ey_s1;
		p_eu_s2 <= ex_s1 * uy_s1;
	end

	// Stage 3: determinant and the two numerators.
	always_ff @(posedge clk) begin
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
		ux_s3  <= ux_s2;
		uy_s3  <= uy_s2;
		det_s3 <= DW'(p_uv_s2) - DW'(p_vu_s2);
		tn_s3  <= DW'(p_ev_s2) - DW'(p_ve_s2);
		sn_s3  <= DW'(p_ue_s2) - DW'(p_eu_s2);
	end

	assign out_valid = valid_s3;
	assign ax  = ax_s3;
	assign ay  = ay_s3;
	assign ux  = ux_s3;
	assign uy  = uy_s3;
	assign det = det_s3;
	assign tn  = tn_s3;
	assign sn  = sn_s3;

endmodule

FILE: rtl/core/ssi_point.sv
module ssi_point #(
	parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic signed [COORD_WIDTH-1:0]   a,
	input  logic signed [COORD_WIDTH:0]     u,
	input  logic signed [2*COORD_WIDTH+2:0] det,
	input  logic signed [2*COORD_WIDTH+2:0] tn,
	output logic [3*COORD_WIDTH+4:0]        mag_n,
	output logic [2*COORD_WIDTH+2:0]        mag_d,
	output logic                            neg
);
	import ssi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = 2 * W + 3;
	localparam int NW = W + DW + 2;
	localparam int LO = DW / 2;
	localparam int HI = DW - LO;

	logic signed [W+LO:0]   a_lo_s4;
	logic signed [W+HI-1:0] a_hi_s4;
	logic signed [W+LO+1:0] u_lo_s4;
	logic signed [W+HI:0]   u_hi_s4;
	logic signed [DW-1:0]   det_s4, det_s5, det_s6;
	logic signed [NW-1:0]   a_part_s5, u_part_s5, num_s6;
	logic [NW-1:0]          mag_n_s7;
	logic [DW-1:0]          mag_d_s7;
	logic                   neg_s7;

	// Stage 4: the products a*det and u*tn, each cut into two partial products.
	always_ff @(posedge clk) begin
		det_s4  <= det;
		a_lo_s4 <= a * $signed({1'b0, det[LO-1:0]});
		a_hi_s4 <= a * $signed(det[DW-1:LO]);
		u_lo_s4 <= u * $signed({1'b0, tn[LO-1:0]});
		u_hi_s4 <= u * $signed(tn[DW-1:LO]);
	end

	// Stage 5: join the partial products of each term.
	always_ff @(posedge clk) begin
		det_s5    <= det_s4;
		a_part_s5 <= (NW'(a_hi_s4) <<< LO) + NW'(a_lo_s4);
		u_part_s5 <= (NW'(u_hi_s4) <<< LO) + NW'(u_lo_s4);
	end

	// Stage 6: numerator a*det + u*tn.
	always_ff @(posedge clk) begin
		det_s6 <= det_s5;
		num_s6 <= a_part_s5 + u_part_s5;
	end

	// Stage 7: magnitudes and quotient sign for the divider.
	always_ff @(posedge clk) begin
		mag_n_s7 <= num_s6[NW-1] ? NW'(-num_s6) : NW'(num_s6);
		mag_d_s7 <= det_s6[DW-1] ? DW'(-det_s6) : DW'(det_s6);
		neg_s7   <= num_s6[NW-1] ^ det_s6[DW-1];
	end

	assign mag_n = mag_n_s7;
	assign mag_d = mag_d_s7;
	assign neg   = neg_s7;

endmodule

FILE: rtl/core/ssi_divider.sv
module ssi_divider #(
	parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic [3*COORD_WIDTH+4:0]     num,
	input  logic [2*COORD_WIDTH+2:0]     den,
	input  logic                         neg,
	output logic [COORD_WIDTH-1:0]       quo,
	output logic                         quo_neg
);
	import ssi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = 2 * W + 3;
	localparam int NW = W + DW + 2;

	logic [NW-1:0] rem_s [0:W];
	logic [DW-1:0] den_s [0:W];
	logic [W-1:0]  quo_s [0:W];
	logic          neg_s [0:W];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign neg_s[0] = neg;

	// One restoring step per stage, most significant quotient bit first.
	for (genvar k = 0; k < W; k++) begin : g_step
		localparam int SH = W - 1 - k;
		logic [NW-1:0] trial;
		logic          fits;

		assign trial = NW'(den_s[k]) << SH;
		assign fits  = rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			rem_s[k+1] <= fits ? rem_s[k] - trial : rem_s[k];
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			quo_s[k+1] <= quo_s[k] | (fits ? W'(1) << SH : W'(0));
		end
	end

	assign quo     = quo_s[W];
	assign quo_neg = neg_s[W];

endmodule
